// ===== hdl/wstd_pkg.sv =====
`timescale 1ns / 1ps

package wstd_pkg;

    // Default number of readings held per wheel window.
    localparam int WINDOW_DEPTH_DEF = 8;

    localparam int DIST_W      = 16;
    localparam int SAMPLE_W    = 15;
    localparam int THR_W       = 15;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [THR_W-1:0] LEFT_THR_RESET  = 15'd12;
    localparam logic [THR_W-1:0] RIGHT_THR_RESET = 15'd6;

    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_THR  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_THR = 8'd1;

    localparam logic WHEEL_LEFT = 1'b1;

    // Bit positions in the result tuser.
    localparam int OUT_USER_W     = 3;
    localparam int OUT_USER_WHEEL = 0;
    localparam int OUT_USER_VALID = 1;
    localparam int OUT_USER_TICK  = 2;

    // Control from the sequencer to the min/max unit.
    typedef struct packed {
        logic init;
        logic fold;
    } wstd_span_ctl_t;

endpackage

// ===== hdl/wstd_ram.sv =====
`timescale 1ns / 1ps

module wstd_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/wstd_span_unit.sv =====
`timescale 1ns / 1ps

module wstd_span_unit
    import wstd_pkg::*;
(
    input  logic                aclk,
    input  wstd_span_ctl_t      ctl,
    input  logic [SAMPLE_W-1:0] init_value,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [THR_W-1:0]    threshold,
    output logic                span_hit
);

    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [SAMPLE_W-1:0] hi_reg, hi_next;
    logic [SAMPLE_W-1:0] span;

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctl.init) begin
            lo_next = init_value;
            hi_next = init_value;
        end else if (ctl.fold) begin
            if (sample < lo_reg) begin
                lo_next = sample;
            end
            if (sample > hi_reg) begin
                hi_next = sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    // The maximum never falls below the minimum, so the difference cannot wrap.
    assign span     = hi_reg - lo_reg;
    assign span_hit = (span >= threshold);

endmodule

// ===== hdl/window_span_tick_detector_unit.sv =====
`timescale 1ns / 1ps

// Blade-pass tick detector for two wheels. Each input word names a wheel in
// tuser and carries a signed distance in tdata. A negative distance goes
// straight to the done state and is passed back as an invalid result. A valid
// reading is written into that wheel's window in RAM (eight entries deep by
// default), the window is then scanned one entry per cycle through the single
// RAM read port, and the span is checked before the result is passed back. The
// next word can be taken once the block is idle again. The block takes one word
// at a time; a finished result waits in the output register while the next word
// is already being worked on, and a result that finds that register still full
// holds the block until it drains. The window RAM needs no clearing after
// reset, as only written entries are ever scanned.
module window_span_tick_detector_unit
    import wstd_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DIST_W-1:0]      s_tdata,   // distance
    input  logic [0:0]             s_tuser,   // wheel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [COUNT_W-1:0]     m_tdata,   // tick_total
    output logic [OUT_USER_W-1:0]  m_tuser,   // wheel_echo, reading_valid, tick
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W    = $clog2(WINDOW_DEPTH);
    localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = FILL_W + 1;
    localparam int ADDR_W   = PTR_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
    localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(WINDOW_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                wheel_reg, wheel_next;
    logic [SAMPLE_W-1:0] value_reg, value_next;
    logic                valid_reg, valid_next;
    logic                tick_reg, tick_next;
    logic [THR_W-1:0]    thr_reg, thr_next;

    logic [THR_W-1:0]    left_thr_reg, left_thr_next;
    logic [THR_W-1:0]    right_thr_reg, right_thr_next;

    logic [FILL_W-1:0]   fill_reg [2];
    logic [FILL_W-1:0]   fill_next [2];
    logic [PTR_W-1:0]    oldest_reg [2];
    logic [PTR_W-1:0]    oldest_next [2];
    logic [COUNT_W-1:0]  count_reg [2];
    logic [COUNT_W-1:0]  count_next [2];

    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [FILL_W-1:0]   iss_reg, iss_next;
    logic                pend_reg, pend_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_wheel_reg, m_wheel_next;
    logic                m_rvalid_reg, m_rvalid_next;
    logic                m_tick_reg, m_tick_next;
    logic [COUNT_W-1:0]  m_total_reg, m_total_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    wstd_span_ctl_t      span_ctl;
    logic                span_hit;

    wstd_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(RAM_DEPTH)
    ) u_window_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    wstd_span_unit u_span (
        .aclk      (aclk),
        .ctl       (span_ctl),
        .init_value(value_reg),
        .sample    (ram_rdata),
        .threshold (thr_reg),
        .span_hit  (span_hit)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign ram_raddr = {wheel_reg, ptr_reg};

    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [PTR_W-1:0] pos;
        logic [PTR_W-1:0] first;

        sum   = '0;
        pos   = '0;
        first = '0;

        state_next    = state_reg;
        wheel_next    = wheel_reg;
        value_next    = value_reg;
        valid_next    = valid_reg;
        tick_next     = tick_reg;
        thr_next      = thr_reg;
        fill_next     = fill_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        iss_next      = iss_reg;
        pend_next     = pend_reg;
        m_wheel_next  = m_wheel_reg;
        m_rvalid_next = m_rvalid_reg;
        m_tick_next   = m_tick_reg;
        m_total_next  = m_total_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = value_reg;
        span_ctl      = '0;

        left_thr_next  = left_thr_reg;
        right_thr_next = right_thr_reg;
        if (cfg_valid) begin
            if (cfg_index == REG_LEFT_THR) begin
                left_thr_next = cfg_data[THR_W-1:0];
            end else if (cfg_index == REG_RIGHT_THR) begin
                right_thr_next = cfg_data[THR_W-1:0];
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    wheel_next = s_tuser[0];
                    value_next = s_tdata[SAMPLE_W-1:0];
                    valid_next = ~s_tdata[DIST_W-1];
                    tick_next  = 1'b0;
                    thr_next   = (s_tuser[0] == WHEEL_LEFT) ? left_thr_reg : right_thr_reg;
                    state_next = s_tdata[DIST_W-1] ? ST_DONE : ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (fill_reg[wheel_reg] == FILL_FULL) begin
                    // Full window: the new reading overwrites the oldest entry.
                    pos   = oldest_reg[wheel_reg];
                    first = (pos == PTR_LAST) ? '0 : pos + 1'b1;
                    oldest_next[wheel_reg] = first;
                end else begin
                    sum = SUM_W'(oldest_reg[wheel_reg]) + SUM_W'(fill_reg[wheel_reg]);
                    if (sum >= SUM_DEPTH) begin
                        sum = sum - SUM_DEPTH;
                    end
                    pos   = sum[PTR_W-1:0];
                    first = oldest_reg[wheel_reg];
                    fill_next[wheel_reg] = fill_reg[wheel_reg] + 1'b1;
                end
                ram_we        = 1'b1;
                ram_waddr     = {wheel_reg, pos};
                span_ctl.init = 1'b1;
                ptr_next      = first;
                iss_next      = '0;
                pend_next     = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                // Reads are issued one per cycle; the data comes back through the RAM's output register.
                span_ctl.fold = pend_reg;
                if (iss_reg != fill_reg[wheel_reg]) begin
                    iss_next  = iss_reg + 1'b1;
                    ptr_next  = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                tick_next = span_hit;
                if (span_hit) begin
                    // Restart the window with only the current reading.
                    oldest_next[wheel_reg] = '0;
                    fill_next[wheel_reg]   = FILL_W'(1);
                    count_next[wheel_reg]  = count_reg[wheel_reg] + 1'b1;
                    ram_we    = 1'b1;
                    ram_waddr = {wheel_reg, {PTR_W{1'b0}}};
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_wheel_next  = wheel_reg;
                    m_rvalid_next = valid_reg;
                    m_tick_next   = tick_reg;
                    m_total_next  = count_reg[wheel_reg];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            left_thr_reg  <= LEFT_THR_RESET;
            right_thr_reg <= RIGHT_THR_RESET;
            fill_reg      <= '{default: '0};
            oldest_reg    <= '{default: '0};
            count_reg     <= '{default: '0};
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            pend_reg      <= pend_next;
            left_thr_reg  <= left_thr_next;
            right_thr_reg <= right_thr_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        wheel_reg    <= wheel_next;
        value_reg    <= value_next;
        valid_reg    <= valid_next;
        tick_reg     <= tick_next;
        thr_reg      <= thr_next;
        ptr_reg      <= ptr_next;
        iss_reg      <= iss_next;
        m_wheel_reg  <= m_wheel_next;
        m_rvalid_reg <= m_rvalid_next;
        m_tick_reg   <= m_tick_next;
        m_total_reg  <= m_total_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_total_reg;
    assign m_tuser[OUT_USER_WHEEL] = m_wheel_reg;
    assign m_tuser[OUT_USER_VALID] = m_rvalid_reg;
    assign m_tuser[OUT_USER_TICK]  = m_tick_reg;

    // A tick can only come from a reading that was processed.
    a_tick_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[OUT_USER_VALID] || !m_tuser[OUT_USER_TICK]))
        else $error("tick reported for an invalid reading");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg[0] <= FILL_FULL) && (fill_reg[1] <= FILL_FULL))
        else $error("window fill beyond its depth");

    // After a tick the window of that wheel holds the current reading only.
    a_tick_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && span_hit) |=>
            (fill_reg[wheel_reg] == FILL_W'(1) && oldest_reg[wheel_reg] == '0))
        else $error("window not restarted after a tick");

    a_scan_not_beyond_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (iss_reg <= fill_reg[wheel_reg]))
        else $error("scan issued more reads than entries held");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wstd_pkg::*;

    localparam int   DEPTH        = WINDOW_DEPTH_DEF;
    localparam int   STALL_LIMIT  = 2000;
    localparam int   REPORT_SLOTS = 16;
    localparam logic WHEEL_RIGHT  = ~WHEEL_LEFT;

    typedef struct packed {
        logic               wheel;
        logic               valid;
        logic               tick;
        logic [COUNT_W-1:0] total;
    } tick_report_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DIST_W-1:0]      s_tdata;   // distance
    logic [0:0]             s_tuser;   // wheel
    logic                   m_tvalid;
    logic                   m_tready;
    logic [COUNT_W-1:0]     m_tdata;   // tick_total
    logic [OUT_USER_W-1:0]  m_tuser;   // wheel_echo, reading_valid, tick
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Own copy of the window state, indexed by wheel (1 left, 0 right).
    logic [SAMPLE_W-1:0] span_window [2][DEPTH];
    int unsigned         span_fill [2];
    int unsigned         span_head [2];
    logic [COUNT_W-1:0]  tick_count [2];
    logic [THR_W-1:0]    span_thr [2];
    int unsigned         level_base [2];

    // Expected results in order of acceptance, kept as a small ring.
    tick_report_t report_ring [REPORT_SLOTS];
    int unsigned  report_wr;
    int unsigned  report_rd;
    int           mismatch_count;
    int           idle_pct;
    bit           quiet;
    int           rx_stall;
    int           idle_cycles;

    window_span_tick_detector_unit #(
        .WINDOW_DEPTH(DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic tick_report_t predict_reading(logic wheel,
                                                     logic [DIST_W-1:0] reading);
        tick_report_t        r;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] d;
        int unsigned         pos;
        r.wheel = wheel;
        r.valid = ~reading[DIST_W-1];
        r.tick  = 1'b0;
        if (r.valid) begin
            sample = reading[SAMPLE_W-1:0];
            if (span_fill[wheel] >= DEPTH) begin
                pos = span_head[wheel];
                span_window[wheel][pos] = sample;
                span_head[wheel] = (pos + 1) % DEPTH;
            end else begin
                pos = (span_head[wheel] + span_fill[wheel]) % DEPTH;
                span_window[wheel][pos] = sample;
                span_fill[wheel]++;
            end
            lo = sample;
            hi = sample;
            for (int i = 0; i < span_fill[wheel]; i++) begin
                d = span_window[wheel][(span_head[wheel] + i) % DEPTH];
                if (d < lo) lo = d;
                if (d > hi) hi = d;
            end
            if (hi - lo >= span_thr[wheel]) begin
                // A tick restarts the window with the current reading alone.
                r.tick = 1'b1;
                span_head[wheel] = 0;
                span_fill[wheel] = 1;
                span_window[wheel][0] = sample;
                tick_count[wheel]++;
            end
        end
        r.total = tick_count[wheel];
        return r;
    endfunction

    task automatic send_reading(input logic wheel, input logic [DIST_W-1:0] reading);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= wheel;
        s_tdata  <= reading;
        do @(posedge aclk); while (!s_tready);
        report_ring[report_wr % REPORT_SLOTS] = predict_reading(wheel, reading);
        report_wr++;
    endtask

    // Leaves the write channel valid so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_LEFT_THR)
            span_thr[WHEEL_LEFT] = val[THR_W-1:0];
        else if (idx == REG_RIGHT_THR)
            span_thr[WHEEL_RIGHT] = val[THR_W-1:0];
    endtask

    task automatic settle_results();
        s_tvalid <= 1'b0;
        while (report_wr != report_rd) @(posedge aclk);
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] left, input logic [THR_W-1:0] right);
        settle_results();
        write_reg(REG_LEFT_THR, {1'($urandom_range(0, 1)), left});
        write_reg(REG_RIGHT_THR, {1'($urandom_range(0, 1)), right});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DIST_W-1:0] pick_distance(logic wheel);
        int unsigned roll;
        int unsigned spread;
        roll   = $urandom_range(0, 99);
        spread = span_thr[wheel] + span_thr[wheel] / 8 + 2;
        if (spread > 32767) spread = 32767;
        if (roll < 4 || level_base[wheel] > 32767 - spread)
            level_base[wheel] = $urandom_range(0, 32767 - spread);
        if (roll < 10) return {1'b1, 15'($urandom)};
        if (roll < 14) return $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
        if (roll < 22) return {1'b0, 15'($urandom)};
        return 16'(level_base[wheel] + $urandom_range(0, spread));
    endfunction

    task automatic test_reset_thresholds();
        idle_pct = 30;
        send_reading(WHEEL_RIGHT, 16'd0);
        send_reading(WHEEL_RIGHT, 16'd5);
        send_reading(WHEEL_RIGHT, 16'd6);
        send_reading(WHEEL_LEFT, 16'd100);
        send_reading(WHEEL_LEFT, 16'd111);
        send_reading(WHEEL_LEFT, 16'd112);
        send_reading(WHEEL_LEFT, 16'h7FFF);
    endtask

    task automatic test_invalid_readings();
        send_reading(WHEEL_LEFT, 16'hFFFF);
        send_reading(WHEEL_RIGHT, 16'h8000);
        send_reading(WHEEL_RIGHT, 16'hC3A5);
    endtask

    task automatic test_window_rollover();
        set_thresholds(15'h7FFF, 15'd10);
        send_reading(WHEEL_RIGHT, 16'h7FFF);
        send_reading(WHEEL_RIGHT, 16'd0);
        // Seven more fill the window, so the next reading pushes out the zero.
        repeat (7) send_reading(WHEEL_RIGHT, 16'd5);
        send_reading(WHEEL_RIGHT, 16'd14);
        send_reading(WHEEL_LEFT, 16'd0);
        send_reading(WHEEL_LEFT, 16'h7FFF);
    endtask

    task automatic test_zero_threshold();
        set_thresholds(15'd0, 15'd0);
        send_reading(WHEEL_LEFT, 16'd7);
        send_reading(WHEEL_RIGHT, 16'd0);
    endtask

    task automatic test_register_writes();
        settle_results();
        write_reg(8'd2, 16'h0000);
        write_reg(8'hFF, 16'hFFFF);
        write_reg(REG_LEFT_THR, 16'hFFFF);
        write_reg(REG_RIGHT_THR, 16'h8005);
        cfg_valid <= 1'b0;
        send_reading(WHEEL_RIGHT, 16'd0);
        send_reading(WHEEL_RIGHT, 16'd5);
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        logic [THR_W-1:0] thr [2];
        for (int p = 0; p < phases; p++) begin
            case (p)
                0: begin thr[1] = 15'd0;    thr[0] = 15'h7FFF; end
                1: begin thr[1] = 15'h7FFF; thr[0] = 15'd0;    end
                2: begin thr[1] = LEFT_THR_RESET; thr[0] = RIGHT_THR_RESET; end
                default: begin
                    for (int w = 0; w < 2; w++)
                        thr[w] = $urandom_range(0, 1) ? 15'($urandom_range(1, 64))
                                                      : 15'($urandom);
                end
            endcase
            set_thresholds(thr[1], thr[0]);
            idle_pct = (p % 3) * 30;
            repeat (per_phase) begin
                automatic logic w = 1'($urandom);
                send_reading(w, pick_distance(w));
            end
        end
    endtask

    task automatic test_back_to_back();
        set_thresholds(15'($urandom_range(1, 200)), 15'($urandom_range(1, 200)));
        quiet = 1'b1;
        repeat (200) begin
            automatic logic w = 1'($urandom);
            send_reading(w, pick_distance(w));
        end
    endtask

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        mismatch_count = 0;
        report_wr = 0;
        report_rd = 0;
        idle_pct = 0;
        quiet = 1'b0;
        span_thr[WHEEL_LEFT]  = LEFT_THR_RESET;
        span_thr[WHEEL_RIGHT] = RIGHT_THR_RESET;
        for (int w = 0; w < 2; w++) begin
            span_fill[w]  = 0;
            span_head[w]  = 0;
            tick_count[w] = '0;
            level_base[w] = 0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_thresholds();
        test_invalid_readings();
        test_window_rollover();
        test_zero_threshold();
        test_register_writes();
        test_random_traffic(8, 240);
        test_back_to_back();

        settle_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        m_tready <= 1'b0;
        rx_stall = 0;
        forever begin
            @(posedge aclk);
            if (rx_stall > 0) begin
                rx_stall--;
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                rx_stall = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        tick_report_t got;
        tick_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.wheel = m_tuser[OUT_USER_WHEEL];
            got.valid = m_tuser[OUT_USER_VALID];
            got.tick  = m_tuser[OUT_USER_TICK];
            got.total = m_tdata;
            if (report_wr == report_rd) begin
                if (mismatch_count < 10)
                    $display("unexpected result word: wheel %0b valid %0b tick %0b total %0d",
                             got.wheel, got.valid, got.tick, got.total);
                mismatch_count++;
            end else begin
                want = report_ring[report_rd % REPORT_SLOTS];
                report_rd++;
                if (got.wheel !== want.wheel || got.valid !== want.valid ||
                    got.tick !== want.tick || got.total !== want.total) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch at %0t: expected wheel %0b valid %0b tick %0b total %0d",
                                 $realtime, want.wheel, want.valid, want.tick, want.total);
                        $display("    got wheel %0b valid %0b tick %0b total %0d",
                                 got.wheel, got.valid, got.tick, got.total);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Any accepted word on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule

// ===== window_span_tick_detector_unit.f =====
hdl/wstd_pkg.sv
hdl/wstd_ram.sv
hdl/wstd_span_unit.sv
hdl/window_span_tick_detector_unit.sv
tb/tb.sv
